[rtl/core/iec_ac3_pkg.sv]
// shared types and constants for the iec 61937 ac-3 burst deframer
// no dependencies; used by every module under rtl/core
`timescale 1ns / 1ps

package iec_ac3_pkg;

	// fixed burst size in bytes
	localparam int BURST_BYTES = 6144;

	// header field constants
	localparam logic [15:0] SYNC_PA   = 16'hf872;
	localparam logic [15:0] SYNC_PB   = 16'h4e1f;
	localparam logic [4:0]  TYPE_AC3  = 5'h01;
	localparam logic [7:0]  TYPE_MASK = 8'h1f;

	// largest accepted payload length in bytes
	localparam logic [12:0] MAX_LEN = 13'(BURST_BYTES - 8);

	// result queue depth (a power of two), pointer and fill widths,
	// and the fill level that still leaves room for two pushes
	localparam int                RQ_DEPTH = 8;
	localparam int                RQ_AW    = $clog2(RQ_DEPTH);
	localparam int                RQ_CW    = $clog2(RQ_DEPTH + 1);
	localparam logic [RQ_CW-1:0]  RQ_ROOM  = RQ_CW'(RQ_DEPTH - 2);

	// header byte positions
	localparam logic [12:0] POS_PA_LO = 13'd0;
	localparam logic [12:0] POS_PA_HI = 13'd1;
	localparam logic [12:0] POS_PB_LO = 13'd2;
	localparam logic [12:0] POS_PB_HI = 13'd3;
	localparam logic [12:0] POS_PC_LO = 13'd4;
	localparam logic [12:0] POS_PD_LO = 13'd6;
	localparam logic [12:0] POS_PD_HI = 13'd7;
	localparam logic [12:0] HDR_BYTES = 13'd8;

	// burst parsing phase
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_PAYLOAD,
		PH_DONE
	} phase_t;

	// status codes
	localparam logic ST_OK  = 1'b0;
	localparam logic ST_BAD = 1'b1;

	// one result item
	typedef struct packed {
		logic [7:0]  out_byte;
		logic        out_last;
		logic        status;
		logic [12:0] frame_length;
	} result_t;

	// up to two results produced by one input byte
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

[rtl/core/iec_ac3_parser.sv]
// input register and burst parser: header checks, pair swap, result generation
// depends on iec_ac3_pkg
`timescale 1ns / 1ps

module iec_ac3_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          data_byte,
	input  logic                burst_start,
	output iec_ac3_pkg::push_t  push
);

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;

	// burst state
	iec_ac3_pkg::phase_t phase_q, phase_d;
	logic [12:0] pos_q, pos_d;
	logic        bad_q, bad_d;
	logic [12:0] plen_q, plen_d;
	logic [7:0]  len_lo_q, len_lo_d;
	logic [7:0]  held_q, held_d;

	// working values
	iec_ac3_pkg::phase_t phase_e;
	logic [12:0] pos_e;
	logic        bad_e;
	logic [12:0] plen_e;
	logic [12:0] hdr_len;
	logic [12:0] off;

	// capture one transaction per cycle while take is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1  <= data_byte;
			start_s1 <= burst_start;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= iec_ac3_pkg::PH_IDLE;
			pos_q    <= '0;
			bad_q    <= 1'b0;
			plen_q   <= '0;
			len_lo_q <= '0;
			held_q   <= '0;
		end else begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			bad_q    <= bad_d;
			plen_q   <= plen_d;
			len_lo_q <= len_lo_d;
			held_q   <= held_d;
		end
	end

	assign hdr_len = 13'({byte_s1, len_lo_q} >> 3);

	// next state and results
	always_comb begin
		phase_e = phase_q;
		pos_e   = pos_q;
		bad_e   = bad_q;
		plen_e  = plen_q;
		if (start_s1) begin
			phase_e = iec_ac3_pkg::PH_HEADER;
			pos_e   = '0;
			bad_e   = 1'b0;
			plen_e  = '0;
		end
		off = pos_e - iec_ac3_pkg::HDR_BYTES;

		phase_d  = phase_q;
		pos_d    = pos_q;
		bad_d    = bad_q;
		plen_d   = plen_q;
		len_lo_d = len_lo_q;
		held_d   = held_q;
		push     = '0;

		if (valid_s1) begin
			phase_d = phase_e;
			pos_d   = pos_e;
			bad_d   = bad_e;
			plen_d  = plen_e;
			unique case (phase_e)
				iec_ac3_pkg::PH_HEADER: begin
					pos_d = pos_e + 13'd1;
					unique case (pos_e)
						iec_ac3_pkg::POS_PA_LO:
							if (byte_s1 != iec_ac3_pkg::SYNC_PA[7:0]) bad_d = 1'b1;
						iec_ac3_pkg::POS_PA_HI:
							if (byte_s1 != iec_ac3_pkg::SYNC_PA[15:8]) bad_d = 1'b1;
						iec_ac3_pkg::POS_PB_LO:
							if (byte_s1 != iec_ac3_pkg::SYNC_PB[7:0]) bad_d = 1'b1;
						iec_ac3_pkg::POS_PB_HI:
							if (byte_s1 != iec_ac3_pkg::SYNC_PB[15:8]) bad_d = 1'b1;
						iec_ac3_pkg::POS_PC_LO:
							if ((byte_s1 & iec_ac3_pkg::TYPE_MASK)
									!= {3'b000, iec_ac3_pkg::TYPE_AC3}) bad_d = 1'b1;
						iec_ac3_pkg::POS_PD_LO:
							len_lo_d = byte_s1;
						iec_ac3_pkg::POS_PD_HI: begin
							if (bad_e || hdr_len == 13'd0 || hdr_len > iec_ac3_pkg::MAX_LEN) begin
								push.count              = 2'd1;
								push.first.out_byte     = 8'h00;
								push.first.out_last     = 1'b1;
								push.first.status       = iec_ac3_pkg::ST_BAD;
								push.first.frame_length = '0;
								phase_d                 = iec_ac3_pkg::PH_DONE;
							end else begin
								plen_d  = hdr_len;
								phase_d = iec_ac3_pkg::PH_PAYLOAD;
							end
						end
						default: ;
					endcase
				end
				iec_ac3_pkg::PH_PAYLOAD: begin
					pos_d = pos_e + 13'd1;
					if (!off[0]) begin
						// even byte waits for its partner
						held_d = byte_s1;
					end else if (off < plen_e) begin
						// swapped pair
						push.count               = 2'd2;
						push.first.out_byte      = byte_s1;
						push.first.out_last      = 1'b0;
						push.first.status        = iec_ac3_pkg::ST_OK;
						push.first.frame_length  = plen_e;
						push.second.out_byte     = held_q;
						push.second.out_last     = (off + 13'd1 == plen_e);
						push.second.status       = iec_ac3_pkg::ST_OK;
						push.second.frame_length = plen_e;
						if (off + 13'd1 == plen_e) phase_d = iec_ac3_pkg::PH_DONE;
					end else begin
						// odd length: odd-position byte alone closes the frame
						push.count              = 2'd1;
						push.first.out_byte     = byte_s1;
						push.first.out_last     = 1'b1;
						push.first.status       = iec_ac3_pkg::ST_OK;
						push.first.frame_length = plen_e;
						phase_d                 = iec_ac3_pkg::PH_DONE;
					end
				end
				default: ; // idle or done: byte ignored
			endcase
		end
	end

endmodule

[rtl/core/iec_ac3_result_queue.sv]
// small result queue taking up to two results per cycle, one out per cycle
// depends on iec_ac3_pkg
`timescale 1ns / 1ps

module iec_ac3_result_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  iec_ac3_pkg::push_t              push,
	output logic [iec_ac3_pkg::RQ_CW-1:0]   fill,
	output logic                            head_valid,
	input  logic                            head_take,
	output iec_ac3_pkg::result_t            head
);

	iec_ac3_pkg::result_t entry_q [iec_ac3_pkg::RQ_DEPTH];
	logic [iec_ac3_pkg::RQ_AW-1:0] wr_q, rd_q;
	logic [iec_ac3_pkg::RQ_CW-1:0] cnt_q;
	logic [iec_ac3_pkg::RQ_AW-1:0] wr_next;

	assign wr_next    = wr_q + {{(iec_ac3_pkg::RQ_AW-1){1'b0}}, 1'b1};
	assign head_valid = (cnt_q != '0);
	assign head       = entry_q[rd_q];
	assign fill       = cnt_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + {{(iec_ac3_pkg::RQ_AW-2){1'b0}}, push.count};
			if (head_take) rd_q <= rd_q + {{(iec_ac3_pkg::RQ_AW-1){1'b0}}, 1'b1};
			cnt_q <= cnt_q + {{(iec_ac3_pkg::RQ_CW-2){1'b0}}, push.count}
				- {{(iec_ac3_pkg::RQ_CW-1){1'b0}}, head_take};
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) entry_q[wr_q] <= push.first;
		if (push.count == 2'd2) entry_q[wr_next] <= push.second;
	end

endmodule

[rtl/core/iec61937_ac3_burst_deframer.sv]
// top level of the iec 61937 ac-3 burst deframer
// depends on iec_ac3_pkg, iec_ac3_parser, iec_ac3_result_queue
//
// usage:
// - input channel (in_valid/in_ready, data_byte, burst_start) takes one burst
//   byte per transaction in wire order; burst_start marks byte 0
// - output channel (out_valid/out_ready, out_byte, out_last, status,
//   frame_length) gives the recovered syncframe bytes, pair-swapped, or one
//   error transaction with status set when the header is rejected
// - a byte is registered, parsed in the next cycle, and its results go into
//   the eight-entry result queue, whose head drives the output
// - throughput is one byte per cycle while in_ready is high; a payload pair
//   yields two results in one cycle, which the queue drains at one per cycle
//   while out_ready is high
// - in_ready drops when the queue fill plus the results of the byte being
//   parsed would leave no room for two more; this happens only when the
//   receiver holds out_ready low
// - reset clears the queue and returns the parser to idle: bytes are ignored
//   until a byte with burst_start arrives
`timescale 1ns / 1ps

module iec61937_ac3_burst_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        burst_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        out_last,
	output logic        status,
	output logic [12:0] frame_length
);

	iec_ac3_pkg::push_t            push;
	iec_ac3_pkg::result_t          head;
	logic [iec_ac3_pkg::RQ_CW-1:0] fill;
	logic                          take;

	// room check for the queue
	assign in_ready = ((fill + {{(iec_ac3_pkg::RQ_CW-2){1'b0}}, push.count})
		<= iec_ac3_pkg::RQ_ROOM);
	assign take     = in_valid & in_ready;

	iec_ac3_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.data_byte   (data_byte),
		.burst_start (burst_start),
		.push        (push)
	);

	iec_ac3_result_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.fill       (fill),
		.head_valid (out_valid),
		.head_take  (out_valid & out_ready),
		.head       (head)
	);

	// output fields
	assign out_byte     = head.out_byte;
	assign out_last     = head.out_last;
	assign status       = head.status;
	assign frame_length = head.frame_length;

endmodule

[sim/tb_iec61937_ac3_burst_deframer.sv]
// testbench for iec61937_ac3_burst_deframer: bursts are fed byte by byte, and each output
// transaction is checked against a built-in burst parser model
// depends on iec_ac3_pkg and the deframer rtl
`timescale 1ns / 1ps

module tb_iec61937_ac3_burst_deframer;

	// header faults that a generated burst can carry
	localparam int FAULT_NONE = 0;
	localparam int FAULT_SYNC = 1;
	localparam int FAULT_TYPE = 2;

	// minimum number of input transactions to generate
	localparam int ITEMS = 500;

	// idle and stall percentages per traffic phase
	localparam int SEND_IDLE[4]  = '{0, 52, 0, 10};
	localparam int RECV_STALL[4] = '{0, 0, 52, 10};

	typedef struct {
		logic [7:0] data;
		logic       start;
		int         phase;
	} burst_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        burst_start = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        out_last;
	logic        status;
	logic [12:0] frame_length;

	burst_byte_t          pending_bytes[$];
	iec_ac3_pkg::result_t expected_frame_bytes[$];
	iec_ac3_pkg::result_t want;
	int          error_count = 0;
	int          cur_phase = 0;
	int          total_items = 0;
	int          accepted_items = 0;

	// model of the parser state
	iec_ac3_pkg::phase_t rx_phase = iec_ac3_pkg::PH_IDLE;
	logic [12:0] rx_pos = '0;
	logic        rx_bad = 1'b0;
	logic [12:0] rx_len = '0;
	logic [7:0]  rx_len_lo = '0;
	logic [7:0]  rx_held = '0;

	iec61937_ac3_burst_deframer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.burst_start  (burst_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.out_last     (out_last),
		.status       (status),
		.frame_length (frame_length)
	);

	always #5 clk = ~clk;

	function automatic iec_ac3_pkg::result_t make_result(input logic [7:0] b,
			input logic last, input logic st, input logic [12:0] len);
		iec_ac3_pkg::result_t r;
		r.out_byte = b;
		r.out_last = last;
		r.status = st;
		r.frame_length = len;
		return r;
	endfunction

	// advance the parser model by one byte and queue the syncframe bytes it yields
	task automatic predict_syncframe(input logic [7:0] b, input logic start);
		logic [12:0] len;
		logic [12:0] off;
		logic        last;
		if (start) begin
			rx_phase = iec_ac3_pkg::PH_HEADER;
			rx_pos = '0;
			rx_bad = 1'b0;
			rx_len = '0;
		end
		if (rx_phase == iec_ac3_pkg::PH_HEADER) begin
			case (rx_pos)
				iec_ac3_pkg::POS_PA_LO:
					if (b != iec_ac3_pkg::SYNC_PA[7:0]) rx_bad = 1'b1;
				iec_ac3_pkg::POS_PA_HI:
					if (b != iec_ac3_pkg::SYNC_PA[15:8]) rx_bad = 1'b1;
				iec_ac3_pkg::POS_PB_LO:
					if (b != iec_ac3_pkg::SYNC_PB[7:0]) rx_bad = 1'b1;
				iec_ac3_pkg::POS_PB_HI:
					if (b != iec_ac3_pkg::SYNC_PB[15:8]) rx_bad = 1'b1;
				iec_ac3_pkg::POS_PC_LO:
					if ((b & iec_ac3_pkg::TYPE_MASK) != {3'b000, iec_ac3_pkg::TYPE_AC3})
						rx_bad = 1'b1;
				iec_ac3_pkg::POS_PD_LO: rx_len_lo = b;
				iec_ac3_pkg::POS_PD_HI: begin
					len = 13'({b, rx_len_lo} >> 3);
					if (rx_bad || len == '0 || len > iec_ac3_pkg::MAX_LEN) begin
						expected_frame_bytes.push_back(
							make_result(8'h00, 1'b1, iec_ac3_pkg::ST_BAD, '0));
						rx_phase = iec_ac3_pkg::PH_DONE;
					end else begin
						rx_len = len;
						rx_phase = iec_ac3_pkg::PH_PAYLOAD;
					end
				end
				default: ;
			endcase
			rx_pos = rx_pos + 13'd1;
		end else if (rx_phase == iec_ac3_pkg::PH_PAYLOAD) begin
			off = rx_pos - iec_ac3_pkg::HDR_BYTES;
			if (!off[0]) begin
				rx_held = b;
			end else if (off < rx_len) begin
				last = (off + 13'd1 == rx_len);
				expected_frame_bytes.push_back(
					make_result(b, 1'b0, iec_ac3_pkg::ST_OK, rx_len));
				expected_frame_bytes.push_back(
					make_result(rx_held, last, iec_ac3_pkg::ST_OK, rx_len));
				if (last) rx_phase = iec_ac3_pkg::PH_DONE;
			end else begin
				// odd length: the odd-position byte goes out alone
				expected_frame_bytes.push_back(
					make_result(b, 1'b1, iec_ac3_pkg::ST_OK, rx_len));
				rx_phase = iec_ac3_pkg::PH_DONE;
			end
			rx_pos = rx_pos + 13'd1;
		end
	endtask

	// queue one byte; the traffic phase follows the share of items already queued
	task automatic push_item(input logic [7:0] b, input logic start);
		burst_byte_t item;
		item.data = b;
		item.start = start;
		item.phase = (total_items < ITEMS) ? (total_items * 4) / ITEMS : 3;
		pending_bytes.push_back(item);
		total_items++;
	endtask

	// queue one burst: header (possibly cut short), payload bytes, then stuffing
	task automatic add_burst(input int len, input int fault, input int hdr_n,
			input int payload_n, input int stuff_n);
		logic [7:0]  hdr[8];
		logic [15:0] pd;
		int          k;
		pd = 16'(len << 3) | 16'($urandom_range(0, 7));
		hdr[0] = iec_ac3_pkg::SYNC_PA[7:0];
		hdr[1] = iec_ac3_pkg::SYNC_PA[15:8];
		hdr[2] = iec_ac3_pkg::SYNC_PB[7:0];
		hdr[3] = iec_ac3_pkg::SYNC_PB[15:8];
		hdr[4] = {3'($urandom_range(0, 7)), iec_ac3_pkg::TYPE_AC3};
		hdr[5] = 8'($urandom);
		hdr[6] = pd[7:0];
		hdr[7] = pd[15:8];
		if (fault == FAULT_SYNC) begin
			k = $urandom_range(0, 3);
			hdr[k] = hdr[k] ^ 8'(1 << $urandom_range(0, 7));
		end else if (fault == FAULT_TYPE) begin
			hdr[4][4:0] = hdr[4][4:0] ^ 5'($urandom_range(1, 31));
		end
		for (k = 0; k < hdr_n; k++) push_item(hdr[k], k == 0);
		for (k = 0; k < payload_n + stuff_n; k++) push_item(8'($urandom), 1'b0);
	endtask

	// input driver: offer the next queued byte, hold it until the transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_syncframe(data_byte, burst_start);
				accepted_items++;
			end
			if (!in_valid || in_ready) begin
				if (pending_bytes.size() > 0 &&
						$urandom_range(0, 99) >= SEND_IDLE[pending_bytes[0].phase]) begin
					in_valid <= 1'b1;
					data_byte <= pending_bytes[0].data;
					burst_start <= pending_bytes[0].start;
					cur_phase = pending_bytes[0].phase;
					pending_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor: random backpressure and comparison with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_frame_bytes.size() == 0) begin
				$display("%0t: unexpected transaction: byte %h last %b status %b length %0d",
					$time, out_byte, out_last, status, frame_length);
				error_count++;
			end else begin
				want = expected_frame_bytes.pop_front();
				if (out_byte !== want.out_byte || out_last !== want.out_last ||
						status !== want.status || frame_length !== want.frame_length) begin
					$display({"%0t: mismatch: expected byte %h last %b status %b length %0d,",
						" got byte %h last %b status %b length %0d"},
						$time, want.out_byte, want.out_last, want.status, want.frame_length,
						out_byte, out_last, status, frame_length);
					error_count++;
				end
			end
		end
		out_ready <= ($urandom_range(0, 99) >= RECV_STALL[cur_phase]);
	end

	initial begin
		int r;
		int len;
		int k;

		// directed: bytes before any burst start, odd length one, zero length,
		// and a burst abandoned by a new start
		push_item(8'h72, 1'b0);
		add_burst(1, FAULT_NONE, 8, 1, 1);
		add_burst(0, FAULT_NONE, 8, 0, 0);
		add_burst(6, FAULT_NONE, 8, 1, 0);

		// longest accepted length (cut short by the next start), then lengths
		// just past the limit and at the top of the length field
		add_burst(int'(iec_ac3_pkg::MAX_LEN), FAULT_NONE, 8, 4, 0);
		add_burst(int'(iec_ac3_pkg::MAX_LEN) + 1, FAULT_NONE, 8, 0, 2);
		add_burst(8191, FAULT_NONE, 8, 0, 1);

		// random bursts: mostly well formed, some rejected, some cut short
		while (total_items < ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 120)
					: $urandom_range(1, 48);
				add_burst(len, FAULT_NONE, 8, len, $urandom_range(0, 5));
			end else if (r < 80) begin
				case ($urandom_range(0, 3))
					0: add_burst($urandom_range(1, 48), FAULT_SYNC, 8, 0, $urandom_range(0, 4));
					1: add_burst($urandom_range(1, 48), FAULT_TYPE, 8, 0, $urandom_range(0, 4));
					2: add_burst(0, FAULT_NONE, 8, 0, $urandom_range(0, 4));
					default: add_burst($urandom_range(int'(iec_ac3_pkg::MAX_LEN) + 1, 8191),
						FAULT_NONE, 8, 0, $urandom_range(0, 4));
				endcase
			end else if (r < 95) begin
				len = $urandom_range(2, 40);
				if ($urandom_range(0, 1))
					add_burst(len, FAULT_NONE, $urandom_range(1, 7), 0, 0);
				else
					add_burst(len, FAULT_NONE, 8, $urandom_range(0, len - 1), 0);
			end else begin
				for (k = 0; k < $urandom_range(1, 6); k++) push_item(8'($urandom), 1'b0);
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_items < total_items) @(posedge clk);
		while (expected_frame_bytes.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0 && expected_frame_bytes.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

[iec61937_ac3_burst_deframer.f]
rtl/core/iec_ac3_pkg.sv
rtl/core/iec_ac3_parser.sv
rtl/core/iec_ac3_result_queue.sv
rtl/core/iec61937_ac3_burst_deframer.sv
sim/tb_iec61937_ac3_burst_deframer.sv
